### design/lpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the levitation pid controller.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int MulAW = 48;  // width of the signed multiplicand
  localparam int MulBW = 16;  // width of the unsigned multiplier, one bit per cycle
  localparam int MulPW = 64;  // product width

  localparam logic [15:0] EchoToCm     = 16'd1124;
  localparam logic [15:0] DtQ16        = 16'd3932;
  localparam logic [15:0] InvDtQ8      = 16'd4267;
  localparam logic [18:0] GateLow      = 19'd512;
  localparam logic [18:0] GateHigh     = 19'd15360;
  localparam logic [15:0] SetpointMin  = 16'd1280;
  localparam logic [2:0]  MissLimit    = 3'd5;
  localparam logic [2:0]  MissSat      = 3'd7;

  localparam logic [2:0] RegPropGain   = 3'd0;
  localparam logic [2:0] RegIntegGain  = 3'd1;
  localparam logic [2:0] RegDerivGain  = 3'd2;
  localparam logic [2:0] RegSmooth     = 3'd3;
  localparam logic [2:0] RegDriveBase  = 3'd4;
  localparam logic [2:0] RegDriveMax   = 3'd5;
  localparam logic [2:0] RegTubeHeight = 3'd6;
  localparam logic [2:0] RegFarLimit   = 3'd7;

  localparam logic [1:0] ModeOff  = 2'd0;
  localparam logic [1:0] ModeFull = 2'd1;
  localparam logic [1:0] ModePid  = 2'd2;

  typedef struct packed {
    logic [15:0] hand_echo_us;
    logic        hand_timeout;
    logic [15:0] ball_echo_us;
    logic        ball_timeout;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  drive_duty;
    logic [1:0]  mode;
    logic [13:0] hand_smoothed;
    logic [13:0] ball_smoothed;
  } out_word_t;

  typedef struct packed {
    logic                    start;
    logic signed [MulAW-1:0] a;
    logic [MulBW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [MulPW-1:0] prod;
  } mul_rsp_t;

endpackage
`default_nettype wire

### design/lpc_serial_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_serial_mul
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lpc_serial_mul (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  lpc_pkg::mul_req_t req_i,
  output lpc_pkg::mul_rsp_t       rsp_o
);
  import lpc_pkg::*;

  logic signed [MulPW-1:0] a_q;
  logic signed [MulPW-1:0] acc_q;
  logic [MulBW-1:0]        b_q;
  logic [3:0]              cnt_q;
  logic                    run_q;
  logic                    done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'(MulBW - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= MulPW'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (run_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule
`default_nettype wire

### design/levitation_pid_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// levitation_pid_controller_unit
// Echo filtering, mode selection and pid drive for a fan levitator.
// ----------------------------------------------------------------------------
// One word is one control cycle. All products go through a single bit-serial
// multiplier, one after another. Every word first runs six products (two echo
// conversions and four filter terms) and a decision state; a fan-off or
// full-drive word then goes to the output register, while a pid word first
// runs six more products. A stalled output register holds the next result
// back until it drains. The block takes one word at a time; a finished result
// sits in the output register while the next word is already being worked on.
module levitation_pid_controller_unit (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               cfg_we_i,
  input  wire  logic [2:0]         cfg_idx_i,
  input  wire  logic [15:0]        cfg_data_i,
  input  wire  logic               in_valid_i,
  output logic                     in_stall_o,
  input  wire  lpc_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire  logic               out_stall_i,
  output lpc_pkg::out_word_t       out_word_o
);
  import lpc_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StHd   = 4'd1;
  localparam logic [3:0] StBd   = 4'd2;
  localparam logic [3:0] StHs1  = 4'd3;
  localparam logic [3:0] StHs2  = 4'd4;
  localparam logic [3:0] StBs1  = 4'd5;
  localparam logic [3:0] StBs2  = 4'd6;
  localparam logic [3:0] StDec  = 4'd7;
  localparam logic [3:0] StP    = 4'd8;
  localparam logic [3:0] StI1   = 4'd9;
  localparam logic [3:0] StStep = 4'd10;
  localparam logic [3:0] StI2   = 4'd11;
  localparam logic [3:0] StD1   = 4'd12;
  localparam logic [3:0] StD2   = 4'd13;
  localparam logic [3:0] StOut  = 4'd14;

  // configuration
  logic [15:0] kp_q, ki_q, kd_q;
  logic [8:0]  sw_q;
  logic [9:0]  base_q, dmax_q;
  logic [13:0] tube_q, far_q;

  // controller state
  logic [13:0]        hand_avg_q, ball_avg_q, prev_q;
  logic [2:0]         miss_q;
  logic signed [31:0] integ_q;

  logic [3:0]         state_q;
  in_word_t           in_q;
  logic [18:0]        hd_q, bd_q;
  logic               hand_ok_q, ball_ok_q;
  logic [23:0]        tmp_q;
  logic signed [17:0] err_q;
  logic signed [31:0] p_q;
  logic signed [39:0] i_q;
  logic               cond_q;
  logic [9:0]         duty_q;
  logic [1:0]         mode_q;
  logic               out_valid_q;
  out_word_t          out_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  lpc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  logic               in_acc;
  logic [8:0]         w, wc;
  logic [18:0]        echo_cm;
  logic               echo_gate;
  logic [23:0]        avg_sum;
  logic [13:0]        avg_new;
  logic signed [15:0] sp;
  logic signed [17:0] err;
  logic               go_pid;
  logic signed [43:0] base_w, top_w, part, total;
  logic signed [39:0] prod_sh;
  logic signed [33:0] acc_sum;
  logic signed [31:0] acc_sat, integ_next;
  logic signed [14:0] diff;
  logic [9:0]         duty_pid;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  assign w         = (sw_q > 9'd256) ? 9'd256 : sw_q;
  assign wc        = 9'd256 - w;
  assign echo_cm   = mrsp.prod[26:8];
  assign echo_gate = (echo_cm > GateLow) && (echo_cm < GateHigh);
  assign avg_sum   = tmp_q + mrsp.prod[23:0];
  assign avg_new   = avg_sum[21:8];

  always_comb begin
    sp = $signed({2'b00, tube_q}) - $signed({2'b00, hand_avg_q});
    if (sp < $signed(SetpointMin)) begin
      sp = $signed(SetpointMin);
    end
  end
  assign err    = $signed({4'b0000, ball_avg_q}) - 18'(sp);
  assign go_pid = (miss_q <= MissLimit) && (ball_avg_q <= far_q);

  assign base_w  = $signed({18'd0, base_q, 16'd0});
  assign top_w   = $signed({18'd0, dmax_q, 16'd0});
  assign prod_sh = mrsp.prod[47:8];  // floor shift by 8
  assign part    = base_w + 44'(p_q) + 44'(prod_sh);

  // integral update with saturation to 32 bits
  assign acc_sum = 34'(integ_q) + 34'($signed(mrsp.prod[31:8]));
  always_comb begin
    if (acc_sum > 34'sh0_7FFF_FFFF) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc_sum < -34'sh0_8000_0000) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end
  assign integ_next = cond_q ? acc_sat : integ_q;

  assign diff  = $signed({1'b0, ball_avg_q}) - $signed({1'b0, prev_q});
  assign total = base_w + 44'(p_q) + 44'(i_q) + 44'(prod_sh);
  always_comb begin
    if (total > top_w) begin
      duty_pid = dmax_q;
    end else if (total < 44'sd0) begin
      duty_pid = '0;
    end else begin
      duty_pid = total[25:16];
    end
  end

  // multiplier launches
  always_comb begin
    mreq = '0;
    case (state_q)
      StIdle: begin
        mreq.start = in_acc;
        mreq.a     = MulAW'({1'b0, in_word_i.hand_echo_us});
        mreq.b     = EchoToCm;
      end
      StHd: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'({1'b0, in_q.ball_echo_us});
        mreq.b     = EchoToCm;
      end
      StBd: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'({1'b0, hd_q});
        mreq.b     = MulBW'(w);
      end
      StHs1: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'({1'b0, hand_avg_q});
        mreq.b     = MulBW'(wc);
      end
      StHs2: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'({1'b0, bd_q});
        mreq.b     = MulBW'(w);
      end
      StBs1: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'({1'b0, ball_avg_q});
        mreq.b     = MulBW'(wc);
      end
      StDec: begin
        mreq.start = go_pid;
        mreq.a     = MulAW'(err);
        mreq.b     = kp_q;
      end
      StP: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'(integ_q);
        mreq.b     = ki_q;
      end
      StI1: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'(err_q);
        mreq.b     = DtQ16;
      end
      StStep: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'(integ_next);
        mreq.b     = ki_q;
      end
      StI2: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'(diff);
        mreq.b     = kd_q;
      end
      StD1: begin
        mreq.start = mrsp.done;
        mreq.a     = MulAW'($signed(mrsp.prod[31:0]));
        mreq.b     = InvDtQ8;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= 16'd3584;
      ki_q   <= 16'd128;
      kd_q   <= 16'd1664;
      sw_q   <= 9'd51;
      base_q <= 10'd950;
      dmax_q <= 10'd999;
      tube_q <= 14'd12800;
      far_q  <= 14'd11520;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPropGain:   kp_q   <= cfg_data_i;
        RegIntegGain:  ki_q   <= cfg_data_i;
        RegDerivGain:  kd_q   <= cfg_data_i;
        RegSmooth:     sw_q   <= cfg_data_i[8:0];
        RegDriveBase:  base_q <= cfg_data_i[9:0];
        RegDriveMax:   dmax_q <= cfg_data_i[9:0];
        RegTubeHeight: tube_q <= cfg_data_i[13:0];
        RegFarLimit:   far_q  <= cfg_data_i[13:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hand_avg_q  <= '0;
      ball_avg_q  <= '0;
      prev_q      <= '0;
      miss_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StOut) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StHd;
          end
        end
        StHd: begin
          if (mrsp.done) begin
            state_q <= StBd;
          end
        end
        StBd: begin
          if (mrsp.done) begin
            state_q <= StHs1;
          end
        end
        StHs1: begin
          if (mrsp.done) begin
            state_q <= StHs2;
          end
        end
        StHs2: begin
          if (mrsp.done) begin
            if (hand_ok_q) begin
              miss_q     <= '0;
              hand_avg_q <= (hand_avg_q == '0) ? hd_q[13:0] : avg_new;
            end else if (miss_q < MissSat) begin
              miss_q <= miss_q + 3'd1;
            end
            state_q <= StBs1;
          end
        end
        StBs1: begin
          if (mrsp.done) begin
            state_q <= StBs2;
          end
        end
        StBs2: begin
          if (mrsp.done) begin
            if (ball_ok_q) begin
              ball_avg_q <= (ball_avg_q == '0) ? bd_q[13:0] : avg_new;
            end
            state_q <= StDec;
          end
        end
        StDec: begin
          if (miss_q > MissLimit) begin
            hand_avg_q <= '0;
            integ_q    <= '0;
            state_q    <= StOut;
          end else if (ball_avg_q > far_q) begin
            state_q <= StOut;
          end else begin
            state_q <= StP;
          end
        end
        StP: begin
          if (mrsp.done) begin
            state_q <= StI1;
          end
        end
        StI1: begin
          if (mrsp.done) begin
            state_q <= StStep;
          end
        end
        StStep: begin
          if (mrsp.done) begin
            integ_q <= integ_next;
            state_q <= StI2;
          end
        end
        StI2: begin
          if (mrsp.done) begin
            state_q <= StD1;
          end
        end
        StD1: begin
          if (mrsp.done) begin
            state_q <= StD2;
          end
        end
        StD2: begin
          if (mrsp.done) begin
            prev_q  <= ball_avg_q;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_word_i;
    end
    if (state_q == StHd && mrsp.done) begin
      hd_q      <= echo_cm;
      hand_ok_q <= !in_q.hand_timeout && echo_gate;
    end
    if (state_q == StBd && mrsp.done) begin
      bd_q      <= echo_cm;
      ball_ok_q <= !in_q.ball_timeout && echo_gate;
    end
    if ((state_q == StHs1 || state_q == StBs1) && mrsp.done) begin
      tmp_q <= mrsp.prod[23:0];
    end
    if (state_q == StDec) begin
      err_q <= err;
      if (miss_q > MissLimit) begin
        duty_q <= '0;
        mode_q <= ModeOff;
      end else if (ball_avg_q > far_q) begin
        duty_q <= dmax_q;
        mode_q <= ModeFull;
      end
    end
    if (state_q == StP && mrsp.done) begin
      p_q <= mrsp.prod[31:0];
    end
    if (state_q == StI1 && mrsp.done) begin
      // integrate only while the partial drive is unsaturated or heading back
      cond_q <= (part > 44'sd0 && part < top_w) || (part >= top_w && err_q < 18'sd0) ||
                (part <= 44'sd0 && err_q > 18'sd0);
    end
    if (state_q == StI2 && mrsp.done) begin
      i_q <= prod_sh;
    end
    if (state_q == StD2 && mrsp.done) begin
      duty_q <= duty_pid;
      mode_q <= ModePid;
    end
    if (state_q == StOut && (!out_valid_q || !out_stall_i)) begin
      out_q.drive_duty    <= duty_q;
      out_q.mode          <= mode_q;
      out_q.hand_smoothed <= hand_avg_q;
      out_q.ball_smoothed <= ball_avg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire
